// File: design/ulm_pkg.sv
// ----------------------------------------------------------------------------
// ulm_pkg: shared types and decode for the UTF-16 lowercase mapper
// Word structs, the mapping class codes and the range decode that sorts a
// code unit into the class that gives its lowercase form.
// ----------------------------------------------------------------------------
package ulm_pkg;

  localparam int unsigned UnitW = 16;

  // first and last code units of the ranges, and the special letters
  localparam logic [UnitW-1:0] AsciiCapFirst    = 16'h0041;
  localparam logic [UnitW-1:0] AsciiCapLast     = 16'h005A;
  localparam logic [UnitW-1:0] FullCapFirst     = 16'hFF21;
  localparam logic [UnitW-1:0] FullCapLast      = 16'hFF3A;
  localparam logic [UnitW-1:0] GreekCapFirst    = 16'h0391;
  localparam logic [UnitW-1:0] GreekCapLast     = 16'h03A9;
  localparam logic [UnitW-1:0] CyrCapFirst      = 16'h0410;
  localparam logic [UnitW-1:0] CyrCapLast       = 16'h042F;
  localparam logic [UnitW-1:0] CyrExtFirst      = 16'h0400;
  localparam logic [UnitW-1:0] CyrExtLast       = 16'h040F;
  localparam logic [UnitW-1:0] Latin1CapFirst   = 16'h00C0;
  localparam logic [UnitW-1:0] Latin1CapLast    = 16'h00DE;
  localparam logic [UnitW-1:0] MulSign          = 16'h00D7;
  localparam logic [UnitW-1:0] CapYDiaeresis    = 16'h0178;
  localparam logic [UnitW-1:0] LowYDiaeresis    = 16'h00FF;
  localparam logic [UnitW-1:0] CapIDotAbove     = 16'h0130;
  localparam logic [UnitW-1:0] LowI             = 16'h0069;
  localparam logic [UnitW-1:0] CapReversedE     = 16'h018E;
  localparam logic [UnitW-1:0] LowTurnedE       = 16'h01DD;
  localparam logic [UnitW-1:0] CapHwair         = 16'h01F6;
  localparam logic [UnitW-1:0] LowHwair         = 16'h0195;
  localparam logic [UnitW-1:0] CapWynn          = 16'h01F7;
  localparam logic [UnitW-1:0] LowWynn          = 16'h01BF;
  localparam logic [UnitW-1:0] LatinAddFirstA   = 16'h1E00;
  localparam logic [UnitW-1:0] LatinAddLastA    = 16'h1E95;
  localparam logic [UnitW-1:0] LatinAddFirstB   = 16'h1EA0;
  localparam logic [UnitW-1:0] LatinAddLastB    = 16'h1EFF;

  // offsets
  localparam logic [UnitW-1:0] CaseOffset       = 16'h0020;
  localparam logic [UnitW-1:0] CyrExtOffset     = 16'h0050;
  localparam logic [UnitW-1:0] DigraphOffset    = 16'h0002;
  localparam logic [UnitW-1:0] TitleOffset      = 16'h0001;

  // pipeline depth seen at the ports, start to done
  localparam int unsigned PipeDepth = 3;

  // input word
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_unit;
  } ulm_in_t;

  // result word
  typedef struct packed {
    logic [UnitW-1:0] lower_unit;
    logic             last_out;
  } ulm_out_t;

  // how a unit turns into its lowercase form
  typedef enum logic [2:0] {
    CLS_KEEP,      // passes unchanged
    CLS_ADD_CASE,  // plus 0x20
    CLS_ADD_CYR,   // plus 0x50
    CLS_SET_LOW,   // or with 1
    CLS_ODD_STEP,  // odd units plus one
    CLS_ADD_DIGR,  // plus 2
    CLS_ADD_TITLE, // plus 1
    CLS_FIXED      // replaced by a fixed letter
  } ulm_cls_t;

  function automatic logic in_rng(input logic [UnitW-1:0] c,
                                  input logic [UnitW-1:0] lo,
                                  input logic [UnitW-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic low_bit_rng(input logic [UnitW-1:0] c);
    return in_rng(c, 16'h0100, 16'h0137) || in_rng(c, 16'h014A, 16'h0177) ||
           in_rng(c, 16'h0180, 16'h0185) || in_rng(c, 16'h0198, 16'h0199) ||
           in_rng(c, 16'h01A0, 16'h01A5) || in_rng(c, 16'h01AC, 16'h01AD) ||
           in_rng(c, 16'h01B8, 16'h01B9) || in_rng(c, 16'h01BC, 16'h01BD) ||
           in_rng(c, 16'h01DE, 16'h01EF) || in_rng(c, 16'h01F4, 16'h01F5) ||
           in_rng(c, 16'h01F8, 16'h01FF);
  endfunction

  function automatic logic odd_step_rng(input logic [UnitW-1:0] c);
    return in_rng(c, 16'h0139, 16'h0148) || in_rng(c, 16'h0179, 16'h017E) ||
           in_rng(c, 16'h0187, 16'h018C) || in_rng(c, 16'h0191, 16'h0192) ||
           in_rng(c, 16'h01A7, 16'h01A8) || in_rng(c, 16'h01AF, 16'h01B0) ||
           in_rng(c, 16'h01B3, 16'h01B6) || in_rng(c, 16'h01CD, 16'h01DC);
  endfunction

  // first matching rule wins
  function automatic ulm_cls_t ulm_classify(input logic [UnitW-1:0] c);
    ulm_cls_t cls;
    cls = CLS_KEEP;
    if (in_rng(c, AsciiCapFirst, AsciiCapLast))        cls = CLS_ADD_CASE;
    else if (in_rng(c, FullCapFirst, FullCapLast))     cls = CLS_ADD_CASE;
    else if (in_rng(c, GreekCapFirst, GreekCapLast))   cls = CLS_ADD_CASE;
    else if (in_rng(c, CyrCapFirst, CyrCapLast))       cls = CLS_ADD_CASE;
    else if (in_rng(c, CyrExtFirst, CyrExtLast))       cls = CLS_ADD_CYR;
    else if (in_rng(c, Latin1CapFirst, Latin1CapLast) && (c != MulSign))
                                                       cls = CLS_ADD_CASE;
    else if (c == CapYDiaeresis || c == CapIDotAbove)  cls = CLS_FIXED;
    else if (low_bit_rng(c))                           cls = CLS_SET_LOW;
    else if (odd_step_rng(c))                          cls = CLS_ODD_STEP;
    else if (c == 16'h01C4 || c == 16'h01C7 || c == 16'h01CA || c == 16'h01F1)
                                                       cls = CLS_ADD_DIGR;
    else if (c == 16'h01C5 || c == 16'h01C8 || c == 16'h01CB || c == 16'h01F2)
                                                       cls = CLS_ADD_TITLE;
    else if (c == CapReversedE || c == CapHwair || c == CapWynn)
                                                       cls = CLS_FIXED;
    else if (in_rng(c, LatinAddFirstA, LatinAddLastA) ||
             in_rng(c, LatinAddFirstB, LatinAddLastB)) cls = CLS_SET_LOW;
    return cls;
  endfunction

  // lowercase letter for the irregular capitals
  function automatic logic [UnitW-1:0] ulm_fixed(input logic [UnitW-1:0] c);
    logic [UnitW-1:0] v;
    v = c;
    if (c == CapYDiaeresis)     v = LowYDiaeresis;
    else if (c == CapIDotAbove) v = LowI;
    else if (c == CapReversedE) v = LowTurnedE;
    else if (c == CapHwair)     v = LowHwair;
    else if (c == CapWynn)      v = LowWynn;
    return v;
  endfunction

endpackage

// File: design/utf16_lowercase_mapper_core.sv
// ----------------------------------------------------------------------------
// utf16_lowercase_mapper_core: lowercase mapping of UTF-16 code units
// Three-stage pipeline: range decode, mapping arithmetic, result register.
// ----------------------------------------------------------------------------
// One code unit enters per clock: busy is always low, so a word is taken at
// every edge where start is high. Its result appears on result with done
// high once the word has passed the three register stages (decode, add,
// output), for one cycle only; the receiver must take it then. Units
// outside the covered letter ranges, surrogate halves included, come back
// unchanged; last_out is a copy of last_unit.
module utf16_lowercase_mapper_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ulm_pkg::ulm_in_t item,
  output logic             done,
  output ulm_pkg::ulm_out_t result
);
  import ulm_pkg::*;

  // stage 1: decoded word
  logic             v1;
  ulm_cls_t         cls1;
  logic [UnitW-1:0] unit1;
  logic [UnitW-1:0] fixed1;
  logic             last1;

  // stage 2: mapped word
  logic             v2;
  logic [UnitW-1:0] unit2;
  logic             last2;
  logic [UnitW-1:0] unit2_next;

  // stage 3: output word
  logic             v3;
  ulm_out_t         res3;

  // no stall source: a word is accepted every cycle
  assign busy = 1'b0;

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1: range decode
  always_ff @(posedge clk) begin
    cls1   <= ulm_classify(item.code_unit);
    fixed1 <= ulm_fixed(item.code_unit);
    unit1  <= item.code_unit;
    last1  <= item.last_unit;
  end

  // stage 2 logic: apply the class
  always_comb begin
    unique case (cls1)
      CLS_KEEP:      unit2_next = unit1;
      CLS_ADD_CASE:  unit2_next = unit1 + CaseOffset;
      CLS_ADD_CYR:   unit2_next = unit1 + CyrExtOffset;
      CLS_SET_LOW:   unit2_next = unit1 | TitleOffset;
      CLS_ODD_STEP:  unit2_next = unit1 + {{(UnitW-1){1'b0}}, unit1[0]};
      CLS_ADD_DIGR:  unit2_next = unit1 + DigraphOffset;
      CLS_ADD_TITLE: unit2_next = unit1 + TitleOffset;
      CLS_FIXED:     unit2_next = fixed1;
      default:       unit2_next = unit1;
    endcase
  end

  always_ff @(posedge clk) begin
    unit2 <= unit2_next;
    last2 <= last1;
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    res3.lower_unit <= unit2;
    res3.last_out   <= last2;
  end

  assign done   = v3;
  assign result = res3;

endmodule

// File: design/ulm_checker.sv
// ----------------------------------------------------------------------------
// ulm_checker: port-level checks for the lowercase mapper
// Watches start, done and the words at the ports and checks the fixed
// latency, flag transport and a sample of the mapping.
// ----------------------------------------------------------------------------
module ulm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ulm_pkg::ulm_in_t  item,
  input logic              done,
  input ulm_pkg::ulm_out_t result
);
  import ulm_pkg::*;

  // every accepted word gives a result after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted word produced no result");

  // no result without a word accepted one pipeline depth before
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without an accepted word");

  // last flag travels with its word
  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.last_out == $past(item.last_unit, 3)))
    else $error("last flag out of step with its word");

  // ascii capitals map by the case offset
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.code_unit >= AsciiCapFirst &&
     item.code_unit <= AsciiCapLast)
    |-> ##3 (result.lower_unit == $past(item.code_unit, 3) + CaseOffset))
    else $error("ascii capital mapped wrong");

endmodule

bind utf16_lowercase_mapper_core ulm_checker u_ulm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
